// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int OUT_CNT_W = 5;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [OUT_CNT_W-1:0]     t_count_out;

    typedef enum logic [0:0] {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic execute;   // apply it to the store and load the result register
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/spq_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
    logic           valid;
    logic           ready;
    spq_pkg::t_mode mode;
    spq_pkg::t_data value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spq_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spq_out_if;
    logic                valid;
    logic                ready;
    spq_pkg::t_data      max_value;
    spq_pkg::t_status    status;
    spq_pkg::t_count_out count_after;
    logic                is_empty;
    logic                is_full;

    modport source (output valid, output max_value, output status, output count_after,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input max_value, input status, input count_after,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output spq_pkg::t_cmd o_cmd
);
    import spq_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   can_exec;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // result register is free, or its transaction completes this cycle
    assign can_exec = !r_out_valid || i_out_ready;

    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC) && can_exec;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_exec) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_cmd       i_cmd,
    input  spq_pkg::t_mode      i_mode,
    input  spq_pkg::t_data      i_value,
    output spq_pkg::t_data      o_max_value,
    output spq_pkg::t_status    o_status,
    output spq_pkg::t_count_out o_count_after,
    output logic                o_is_empty,
    output logic                o_is_full
);
    import spq_pkg::*;

    // transaction latched at accept
    t_mode      r_mode;
    t_data      r_value;

    // sorted store, ascending, one compare cell per entry
    t_data      r_store [CAPACITY];
    t_data      n_store [CAPACITY];
    logic [CAPACITY-1:0] gt;

    t_count     r_count, n_count;
    t_count     cnt_m1;
    t_idx       top_idx;
    logic       now_full, now_empty;
    logic       do_write;

    // result register
    t_data      r_max, n_max;
    t_status    r_status, n_status;
    t_count_out r_cnt_out;
    logic       r_empty, r_full;

    assign now_full  = (r_count == CNT_W'(CAPACITY));
    assign now_empty = (r_count == '0);
    assign cnt_m1    = r_count - 1'b1;
    assign top_idx   = cnt_m1[IDX_W-1:0];

    // gt is monotonic over valid entries: everything above the insertion point shifts up
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign gt[g] = (CNT_W'(g) < r_count) && (r_store[g] > r_value);
        if (g == 0) begin : g_bottom
            assign n_store[g] = (gt[g] || (r_count == '0)) ? r_value : r_store[g];
        end else begin : g_upper
            assign n_store[g] = gt[g-1] ? r_store[g-1] :
                                (gt[g] || (CNT_W'(g) == r_count)) ? r_value : r_store[g];
        end
    end

    always_comb begin
        n_count  = r_count;
        n_max    = '0;
        n_status = ST_OK;
        do_write = 1'b0;
        unique case (r_mode)
            MODE_ENQ: begin
                if (now_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_write = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_DEQ: begin
                if (now_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = cnt_m1;
                    n_max   = r_store[top_idx];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.execute) begin
            r_max     <= n_max;
            r_status  <= n_status;
            r_cnt_out <= OUT_CNT_W'(n_count);
            r_empty   <= (n_count == '0);
            r_full    <= (n_count == CNT_W'(CAPACITY));
            if (do_write) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    r_store[i] <= n_store[i];
                end
            end
        end
    end

    assign o_max_value   = r_max;
    assign o_status      = r_status;
    assign o_count_after = r_cnt_out;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_array_priority_queue.sv
// Max priority queue over signed 32-bit values, kept in an ascending sorted store.
// Input channel (i_in): mode 0 enqueues value, mode 1 dequeues the largest entry.
// Output channel (o_out): one result per input transaction with the removed maximum
// (0 unless a dequeue succeeded), status (ok / enqueue dropped on full / dequeue on
// empty), the count afterwards and empty/full flags.
// Timing: a transaction is captured when accepted and applied in the controller's execute
// step, which loads the result register; the input is not ready again until that step is
// done. An insertion is done at once by a compare cell per store entry that shifts larger
// entries up.
// Stall: the result stays in the output register until taken; the next transaction
// may be accepted meanwhile, but its execute step waits for the register to empty,
// and the input is not ready during that wait.
// Reset (synchronous, active low): the queue becomes empty and no result is pending;
// store contents are left as they are and are never read before being written.
// Equal values: a newly enqueued value leaves before earlier equal ones.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_priority_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    t_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    spq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_in.mode),
        .i_value       (i_in.value),
        .o_max_value   (o_out.max_value),
        .o_status      (o_out.status),
        .o_count_after (o_out.count_after),
        .o_is_empty    (o_out.is_empty),
        .o_is_full     (o_out.is_full)
    );

endmodule

`default_nettype wire

// File: hw/rtl/spq_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input spq_pkg::t_data      i_max_value,
    input spq_pkg::t_status    i_status,
    input spq_pkg::t_count_out i_count_after,
    input logic                i_is_empty,
    input logic                i_is_full
);
    import spq_pkg::*;

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_count_after == '0) || CAPACITY > 31))
        else $error("is_empty disagrees with count_after");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_FULL) |-> (i_is_full && i_max_value == '0))
        else $error("dropped enqueue without full queue or with nonzero value");

    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_EMPTY) |-> (i_is_empty && i_max_value == '0))
        else $error("empty dequeue reported with entries or nonzero value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind sorted_array_priority_queue spq_chk u_spq_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_max_value   (o_out.max_value),
    .i_status      (o_out.status),
    .i_count_after (o_out.count_after),
    .i_is_empty    (o_out.is_empty),
    .i_is_full     (o_out.is_full)
);

`default_nettype wire

// File: dv/sorted_array_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_array_priority_queue_tb;
    import spq_pkg::*;

    localparam int RX_HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PCT       = 35;

    typedef struct {
        t_mode mode;
        t_data value;
    } t_pq_op;

    typedef struct {
        t_data      max_value;
        t_status    status;
        t_count_out count_after;
        logic       is_empty;
        logic       is_full;
    } t_pq_result;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_array_priority_queue i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow copy of the queue contents
    t_data      pq_store [CAPACITY];
    int         pq_count;

    t_pq_op     pending_ops[$];
    t_pq_result expected_results[$];
    t_pq_op     next_op;

    logic       in_taken;
    logic       no_idle;
    int         rx_hold_reqs;
    int         rx_hold_served;
    int         rx_hold_left;
    int         cycle_cnt;
    int         errors;
    int         n_enq, n_deq, n_full_drop, n_empty_deq, n_checked, max_seen_count;

    function automatic t_pq_result pq_apply(t_mode m, t_data v);
        t_pq_result r;
        int         pos;
        r.max_value = '0;
        r.status    = ST_OK;
        if (m == MODE_ENQ) begin
            if (pq_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                pos = pq_count;
                // strictly greater entries move up, so v lands above equal ones
                while (pos > 0 && pq_store[pos-1] > v) begin
                    pq_store[pos] = pq_store[pos-1];
                    pos--;
                end
                pq_store[pos] = v;
                pq_count++;
            end
        end else if (pq_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            pq_count--;
            r.max_value = pq_store[pq_count];
        end
        r.count_after = t_count_out'(pq_count);
        r.is_empty    = (pq_count == 0);
        r.is_full     = (pq_count == CAPACITY);
        return r;
    endfunction

    function automatic t_data rand_value();
        case ($urandom_range(9))
            0, 1, 2: return t_data'(int'($urandom_range(8)) - 4);  // many ties
            3:       return $urandom_range(1) ? t_data'(32'h7fff_ffff) : t_data'(32'h8000_0000);
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic push_op(t_mode m, t_data v);
        t_pq_op op;
        op.mode  = m;
        op.value = v;
        pending_ops.push_back(op);
    endtask

    // alternate fill-biased and drain-biased runs so full and empty both recur
    task automatic push_random(int n);
        int enq_pct;
        for (int i = 0; i < n; i++) begin
            enq_pct = ((i / 24) % 2 == 0) ? 75 : 25;
            push_op(($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ, rand_value());
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sender
    always @(negedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_ops.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                next_op = pending_ops.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.mode  <= next_op.mode;
                in_ch.value <= next_op.value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver, with long hold-offs on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (rx_hold_reqs != rx_hold_served) begin
            rx_hold_served <= rx_hold_served + 1;
            rx_hold_left   <= RX_HOLD_CYCLES;
            out_ch.ready   <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge clk) begin
        t_pq_result exp_r;
        if (!rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                exp_r = pq_apply(in_ch.mode, in_ch.value);
                expected_results.push_back(exp_r);
                if (in_ch.mode == MODE_ENQ) n_enq++;
                else                        n_deq++;
                if (exp_r.status == ST_FULL)  n_full_drop++;
                if (exp_r.status == ST_EMPTY) n_empty_deq++;
                if (pq_count > max_seen_count) max_seen_count = pq_count;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result max_value=%0d status=%0d count=%0d",
                             $time, out_ch.max_value, out_ch.status, out_ch.count_after);
                end else begin
                    exp_r = expected_results.pop_front();
                    n_checked++;
                    if (out_ch.max_value !== exp_r.max_value) begin
                        errors++;
                        $display("%0t: max_value expected %0d actual %0d",
                                 $time, exp_r.max_value, out_ch.max_value);
                    end
                    if (out_ch.status !== exp_r.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, out_ch.status);
                    end
                    if (out_ch.count_after !== exp_r.count_after) begin
                        errors++;
                        $display("%0t: count_after expected %0d actual %0d",
                                 $time, exp_r.count_after, out_ch.count_after);
                    end
                    if (out_ch.is_empty !== exp_r.is_empty) begin
                        errors++;
                        $display("%0t: is_empty expected %0b actual %0b",
                                 $time, exp_r.is_empty, out_ch.is_empty);
                    end
                    if (out_ch.is_full !== exp_r.is_full) begin
                        errors++;
                        $display("%0t: is_full expected %0b actual %0b",
                                 $time, exp_r.is_full, out_ch.is_full);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("sorted_array_priority_queue_tb NOT OK");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_ENQ;
        in_ch.value    = '0;
        out_ch.ready   = 1'b0;
        in_taken       = 1'b0;
        no_idle        = 1'b0;
        rx_hold_reqs   = 0;
        rx_hold_served = 0;
        rx_hold_left   = 0;
        cycle_cnt      = 0;
        errors         = 0;
        n_enq = 0; n_deq = 0; n_full_drop = 0; n_empty_deq = 0;
        n_checked = 0; max_seen_count = 0;
        pq_count       = 0;
        foreach (pq_store[i]) pq_store[i] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty dequeue, extremes, ties, fill up, drop on full, partial drain
        push_op(MODE_DEQ, t_data'(32'hffff_ffff));
        push_op(MODE_ENQ, t_data'(32'h8000_0000));
        push_op(MODE_ENQ, t_data'(32'h7fff_ffff));
        push_op(MODE_ENQ, t_data'(0));
        push_op(MODE_ENQ, t_data'(-1));
        push_op(MODE_ENQ, t_data'(1));
        push_op(MODE_ENQ, t_data'(0));
        push_op(MODE_ENQ, t_data'(32'h7fff_ffff));
        push_op(MODE_ENQ, t_data'(32'h8000_0000));
        push_op(MODE_ENQ, t_data'(32'h5555_5555));
        push_op(MODE_ENQ, t_data'(32'haaaa_aaaa));
        for (int i = 0; i < 6; i++) push_op(MODE_ENQ, rand_value());
        push_op(MODE_ENQ, t_data'(7));
        for (int i = 0; i < 5; i++) push_op(MODE_DEQ, '0);
        wait_drained();

        // receiver stalls while the sender keeps going
        push_random(40);
        rx_hold_reqs = rx_hold_reqs + 1;
        while (pending_ops.size() != 0) @(posedge clk);

        // back-to-back stretch
        no_idle = 1'b1;
        push_random(150);
        while (pending_ops.size() != 0) @(posedge clk);
        no_idle = 1'b0;

        push_random(490);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("ran %0d enqueues and %0d dequeues, %0d results checked, peak fill %0d",
                 n_enq, n_deq, n_checked, max_seen_count);
        $display("drops on full: %0d, dequeues on empty: %0d", n_full_drop, n_empty_deq);
        if (errors == 0) begin
            $display("sorted_array_priority_queue_tb OK");
        end else begin
            $display("sorted_array_priority_queue_tb NOT OK");
        end
        $finish;
    end

endmodule
